// ----- src/pn3d_pkg.sv -----
// Package for the 3D gradient noise unit: permutation and easing tables,
// gradient dot product and item widths. No dependencies.
`default_nettype none
package pn3d_pkg;

    localparam int CoordW = 16;
    localparam int NoiseW = 17;
    // dot product of fractional offsets with a gradient: |v| <= 512
    localparam int DotW   = 11;
    // x blend after shift: |l| <= 512*64 scale
    localparam int LerpW  = 17;

    typedef logic signed [DotW-1:0]  dot_t;
    typedef logic signed [LerpW-1:0] lerp_t;

    function automatic logic [7:0] perm(input logic [7:0] i);
        logic [7:0] r;
        unique case (i)
            8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
            8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
            8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
            8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
            8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
            8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
            8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
            8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
            8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
            8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
            8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
            8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
            8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
            8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
            8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
            8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
            8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
            8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
            8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
            8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
            8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
            8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
            8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
            8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
            8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
            8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
            8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
            8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
            8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
            8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
            8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
            8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
            8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
            8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
            8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
            8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
            8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
            8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
            8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
            8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
            8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
            8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
            8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
            8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
            8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
            8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
            8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
            8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
            8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
            8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
            8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
            8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
            8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
            8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
            8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
            8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
            8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
            8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
            8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
            8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
            8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
            8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
            8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
            8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    localparam logic [11:0] EaseTab [256] = '{
        12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
        12'd1, 12'd1, 12'd2, 12'd3, 12'd3, 12'd4, 12'd6, 12'd7,
        12'd9, 12'd10, 12'd12, 12'd14, 12'd17, 12'd19, 12'd22, 12'd25,
        12'd29, 12'd32, 12'd36, 12'd40, 12'd45, 12'd49, 12'd54, 12'd60,
        12'd65, 12'd71, 12'd77, 12'd84, 12'd91, 12'd98, 12'd105, 12'd113,
        12'd121, 12'd130, 12'd139, 12'd148, 12'd158, 12'd167, 12'd178, 12'd188,
        12'd199, 12'd211, 12'd222, 12'd234, 12'd247, 12'd259, 12'd273, 12'd286,
        12'd300, 12'd314, 12'd329, 12'd344, 12'd359, 12'd374, 12'd390, 12'd407,
        12'd424, 12'd441, 12'd458, 12'd476, 12'd494, 12'd512, 12'd531, 12'd550,
        12'd570, 12'd589, 12'd609, 12'd630, 12'd651, 12'd672, 12'd693, 12'd715,
        12'd737, 12'd759, 12'd782, 12'd805, 12'd828, 12'd851, 12'd875, 12'd899,
        12'd923, 12'd948, 12'd973, 12'd998, 12'd1023, 12'd1049, 12'd1074, 12'd1100,
        12'd1127, 12'd1153, 12'd1180, 12'd1207, 12'd1234, 12'd1261, 12'd1289, 12'd1316,
        12'd1344, 12'd1372, 12'd1400, 12'd1429, 12'd1457, 12'd1486, 12'd1515, 12'd1543,
        12'd1572, 12'd1602, 12'd1631, 12'd1660, 12'd1690, 12'd1719, 12'd1749, 12'd1778,
        12'd1808, 12'd1838, 12'd1868, 12'd1898, 12'd1928, 12'd1958, 12'd1988, 12'd2018,
        12'd2048, 12'd2077, 12'd2107, 12'd2137, 12'd2167, 12'd2197, 12'd2227, 12'd2257,
        12'd2287, 12'd2317, 12'd2346, 12'd2376, 12'd2405, 12'd2435, 12'd2464, 12'd2493,
        12'd2523, 12'd2552, 12'd2580, 12'd2609, 12'd2638, 12'd2666, 12'd2695, 12'd2723,
        12'd2751, 12'd2779, 12'd2806, 12'd2834, 12'd2861, 12'd2888, 12'd2915, 12'd2942,
        12'd2968, 12'd2995, 12'd3021, 12'd3046, 12'd3072, 12'd3097, 12'd3122, 12'd3147,
        12'd3172, 12'd3196, 12'd3220, 12'd3244, 12'd3267, 12'd3290, 12'd3313, 12'd3336,
        12'd3358, 12'd3380, 12'd3402, 12'd3423, 12'd3444, 12'd3465, 12'd3486, 12'd3506,
        12'd3525, 12'd3545, 12'd3564, 12'd3583, 12'd3601, 12'd3619, 12'd3637, 12'd3654,
        12'd3672, 12'd3688, 12'd3705, 12'd3721, 12'd3736, 12'd3751, 12'd3766, 12'd3781,
        12'd3795, 12'd3809, 12'd3822, 12'd3836, 12'd3848, 12'd3861, 12'd3873, 12'd3884,
        12'd3896, 12'd3907, 12'd3917, 12'd3928, 12'd3937, 12'd3947, 12'd3956, 12'd3965,
        12'd3974, 12'd3982, 12'd3990, 12'd3997, 12'd4004, 12'd4011, 12'd4018, 12'd4024,
        12'd4030, 12'd4035, 12'd4041, 12'd4046, 12'd4050, 12'd4055, 12'd4059, 12'd4063,
        12'd4066, 12'd4070, 12'd4073, 12'd4076, 12'd4078, 12'd4081, 12'd4083, 12'd4085,
        12'd4086, 12'd4088, 12'd4089, 12'd4091, 12'd4092, 12'd4092, 12'd4093, 12'd4094,
        12'd4094, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095
    };

    // Offsets are signed 10-bit: fraction (0..255) or fraction - 256
    function automatic dot_t grad_dot(input logic [3:0] h,
                                      input logic signed [9:0] dx,
                                      input logic signed [9:0] dy,
                                      input logic signed [9:0] dz);
        dot_t x, y, z, r;
        x = DotW'(dx);
        y = DotW'(dy);
        z = DotW'(dz);
        unique case (h)
            4'd0:  r =  x + y;
            4'd1:  r = -x + y;
            4'd2:  r =  x - y;
            4'd3:  r = -x - y;
            4'd4:  r =  x + z;
            4'd5:  r = -x + z;
            4'd6:  r =  x - z;
            4'd7:  r = -x - z;
            4'd8:  r =  y + z;
            4'd9:  r = -y + z;
            4'd10: r =  y - z;
            4'd11: r = -y - z;
            4'd12: r =  x - z;
            4'd13: r = -x - z;
            4'd14: r = -y + z;
            4'd15: r =  y + z;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/pn3d_lerp.sv -----
// One blend stage: registered (a<<12) + t*(b-a), then floor shift.
// Depends on pn3d_pkg for the LerpW width.
`default_nettype none
module pn3d_lerp
    import pn3d_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic [11:0]              t,
    input  wire logic signed [LerpW-1:0]  a,
    input  wire logic signed [LerpW-1:0]  b,
    input  wire logic                     shift_sel,
    output logic signed [LerpW-1:0]       y
);
    logic signed [LerpW:0]     diff;
    logic signed [LerpW+13:0]  prod;
    logic signed [LerpW+14:0]  sum;

    assign diff = {a[LerpW-1], a} - {b[LerpW-1], b};
    assign prod = (LerpW+14)'(-diff) * $signed({1'b0, t});
    assign sum  = {{3{a[LerpW-1]}}, a, 12'd0} + {prod[LerpW+13], prod};

    // arithmetic right shift floors; shift_sel chooses 6 or 12
    always_ff @(posedge aclk) begin
        if (en) begin
            if (shift_sel) begin
                y <= LerpW'(sum >>> 6);
            end else begin
                y <= LerpW'(sum >>> 12);
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/perlin_noise_3d_fixed_unit.sv -----
// 3D gradient noise unit, one coordinate triple in, one noise sample out.
// Channels: s_axis_tdata holds coord_x, coord_y, coord_z (lowest first);
// m_axis_tdata holds noise_value, 17-bit two's complement, zero filled.
// Pipeline: S1 first hash + easing, S2 second hash, S3 corner hashes,
// S4 gradient dots, S5 x blend, S6 y blend, S7 z blend (output register).
// Seven register stages; m_axis_tvalid rises when the item reaches the S7
// output register.
// Throughput is one item per cycle while the receiver does not stall; each stage
// holds one table read or one multiply-add, so the rate is set by the plain pipeline.
// Reset (aresetn low, synchronous) drops every item in flight.
// When the receiver stalls the whole pipeline holds; a bubble in it is
// filled, so s_axis_tready stays high while any stage is empty.
// Depends on pn3d_pkg and pn3d_lerp.
`default_nettype none
module perlin_noise_3d_fixed_unit
    import pn3d_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // coord_x[15:0], coord_y[31:16], coord_z[47:32]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // noise_value[16:0], zero fill above
);
    localparam int NStg = 7;

    logic [NStg-1:0] vld_reg, vld_next;
    logic [NStg-1:0] adv;

    // stage enables: a stage moves when the one after it moves or is empty
    always_comb begin
        adv[NStg-1] = m_axis_tready || !vld_reg[NStg-1];
        for (int i = NStg-2; i >= 0; i--) begin
            adv[i] = adv[i+1] || !vld_reg[i];
        end
        vld_next[0] = adv[0] ? s_axis_tvalid : vld_reg[0];
        for (int i = 1; i < NStg; i++) begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = vld_reg[NStg-1];

    logic [15:0] cx, cy, cz;
    assign cx = s_axis_tdata[15:0];
    assign cy = s_axis_tdata[31:16];
    assign cz = s_axis_tdata[47:32];

    // S1
    logic [7:0]  s1_a_reg, s1_b_reg, s1_j_reg, s1_k_reg;
    logic [7:0]  s1_fx_reg, s1_fy_reg, s1_fz_reg;
    logic [11:0] s1_tx_reg, s1_ty_reg, s1_tz_reg;
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s1_a_reg  <= perm(cx[15:8]);
            s1_b_reg  <= perm(cx[15:8] + 8'd1);
            s1_j_reg  <= cy[15:8];
            s1_k_reg  <= cz[15:8];
            s1_fx_reg <= cx[7:0];
            s1_fy_reg <= cy[7:0];
            s1_fz_reg <= cz[7:0];
            s1_tx_reg <= EaseTab[cx[7:0]];
            s1_ty_reg <= EaseTab[cy[7:0]];
            s1_tz_reg <= EaseTab[cz[7:0]];
        end
    end

    // S2
    logic [7:0]  s2_aa_reg, s2_ab_reg, s2_ba_reg, s2_bb_reg, s2_k_reg;
    logic [7:0]  s2_fx_reg, s2_fy_reg, s2_fz_reg;
    logic [11:0] s2_tx_reg, s2_ty_reg, s2_tz_reg;
    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s2_aa_reg <= perm(s1_a_reg + s1_j_reg);
            s2_ab_reg <= perm(s1_a_reg + s1_j_reg + 8'd1);
            s2_ba_reg <= perm(s1_b_reg + s1_j_reg);
            s2_bb_reg <= perm(s1_b_reg + s1_j_reg + 8'd1);
            s2_k_reg  <= s1_k_reg;
            s2_fx_reg <= s1_fx_reg;
            s2_fy_reg <= s1_fy_reg;
            s2_fz_reg <= s1_fz_reg;
            s2_tx_reg <= s1_tx_reg;
            s2_ty_reg <= s1_ty_reg;
            s2_tz_reg <= s1_tz_reg;
        end
    end

    // S3: corner hashes, order g1..g8
    logic [3:0]  s3_h_reg [8];
    logic [7:0]  s3_fx_reg, s3_fy_reg, s3_fz_reg;
    logic [11:0] s3_tx_reg, s3_ty_reg, s3_tz_reg;
    logic [7:0]  k1;
    logic [7:0]  crn_hash [8];
    assign k1 = s2_k_reg + 8'd1;
    always_comb begin
        crn_hash[0] = perm(s2_aa_reg + s2_k_reg);
        crn_hash[1] = perm(s2_ba_reg + s2_k_reg);
        crn_hash[2] = perm(s2_ab_reg + s2_k_reg);
        crn_hash[3] = perm(s2_bb_reg + s2_k_reg);
        crn_hash[4] = perm(s2_aa_reg + k1);
        crn_hash[5] = perm(s2_ba_reg + k1);
        crn_hash[6] = perm(s2_ab_reg + k1);
        crn_hash[7] = perm(s2_bb_reg + k1);
    end
    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            for (int i = 0; i < 8; i++) begin
                s3_h_reg[i] <= crn_hash[i][3:0];
            end
            s3_fx_reg <= s2_fx_reg;
            s3_fy_reg <= s2_fy_reg;
            s3_fz_reg <= s2_fz_reg;
            s3_tx_reg <= s2_tx_reg;
            s3_ty_reg <= s2_ty_reg;
            s3_tz_reg <= s2_tz_reg;
        end
    end

    // S4: gradient dot products
    logic signed [9:0] fx0, fy0, fz0, fx1, fy1, fz1;
    assign fx0 = $signed({2'b00, s3_fx_reg});
    assign fy0 = $signed({2'b00, s3_fy_reg});
    assign fz0 = $signed({2'b00, s3_fz_reg});
    assign fx1 = fx0 - 10'sd256;
    assign fy1 = fy0 - 10'sd256;
    assign fz1 = fz0 - 10'sd256;

    lerp_t       s4_g_reg [8];
    logic [11:0] s4_tx_reg, s4_ty_reg, s4_tz_reg;
    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s4_g_reg[0] <= LerpW'(grad_dot(s3_h_reg[0], fx0, fy0, fz0));
            s4_g_reg[1] <= LerpW'(grad_dot(s3_h_reg[1], fx1, fy0, fz0));
            s4_g_reg[2] <= LerpW'(grad_dot(s3_h_reg[2], fx0, fy1, fz0));
            s4_g_reg[3] <= LerpW'(grad_dot(s3_h_reg[3], fx1, fy1, fz0));
            s4_g_reg[4] <= LerpW'(grad_dot(s3_h_reg[4], fx0, fy0, fz1));
            s4_g_reg[5] <= LerpW'(grad_dot(s3_h_reg[5], fx1, fy0, fz1));
            s4_g_reg[6] <= LerpW'(grad_dot(s3_h_reg[6], fx0, fy1, fz1));
            s4_g_reg[7] <= LerpW'(grad_dot(s3_h_reg[7], fx1, fy1, fz1));
            s4_tx_reg <= s3_tx_reg;
            s4_ty_reg <= s3_ty_reg;
            s4_tz_reg <= s3_tz_reg;
        end
    end

    // S5: x blends
    lerp_t       s5_l_reg [4];
    logic [11:0] s5_ty_reg, s5_tz_reg;
    for (genvar i = 0; i < 4; i++) begin : g_xl
        pn3d_lerp u_xl (
            .aclk(aclk), .en(adv[4]), .t(s4_tx_reg),
            .a(s4_g_reg[2*i]), .b(s4_g_reg[2*i+1]),
            .shift_sel(1'b1), .y(s5_l_reg[i])
        );
    end
    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s5_ty_reg <= s4_ty_reg;
            s5_tz_reg <= s4_tz_reg;
        end
    end

    // S6: y blends
    lerp_t       s6_l_reg [2];
    logic [11:0] s6_tz_reg;
    for (genvar i = 0; i < 2; i++) begin : g_yl
        pn3d_lerp u_yl (
            .aclk(aclk), .en(adv[5]), .t(s5_ty_reg),
            .a(s5_l_reg[2*i]), .b(s5_l_reg[2*i+1]),
            .shift_sel(1'b0), .y(s6_l_reg[i])
        );
    end
    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            s6_tz_reg <= s5_tz_reg;
        end
    end

    // S7: z blend into the output register
    lerp_t s7_out_reg;
    pn3d_lerp u_zl (
        .aclk(aclk), .en(adv[6]), .t(s6_tz_reg),
        .a(s6_l_reg[0]), .b(s6_l_reg[1]),
        .shift_sel(1'b0), .y(s7_out_reg)
    );

    assign m_axis_tdata = {7'd0, s7_out_reg[NoiseW-1:0]};
endmodule
`default_nettype wire
